### rtl/page_share_refcount_table_top_assert.svh
// Assertion macros shared by the page share refcount table RTL.
// Depends on nothing; expects signals clk and rst in the including module.
`ifndef PAGE_SHARE_REFCOUNT_TABLE_TOP_ASSERT_SVH
`define PAGE_SHARE_REFCOUNT_TABLE_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PSRT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define PSRT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/psrt_pkg.sv
// Shared types and constants for the page share refcount table.
// No dependencies.
`default_nettype none

package psrt_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int COUNT_BITS  = 10;
  localparam int ADDR_BITS   = 20;

  localparam int MODE_W      = 2;
  localparam int IN_ADDR_W   = 20;
  localparam int OUT_COUNT_W = 10;
  localparam int STATUS_W    = 2;

  localparam int IDX_W   = $clog2(TABLE_DEPTH);
  localparam int SCAN_W  = $clog2(TABLE_DEPTH + 1);
  localparam int ENTRY_W = 1 + ADDR_BITS + COUNT_BITS;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  typedef enum logic [MODE_W-1:0] {
    MODE_QUERY = 2'd0,
    MODE_INC   = 2'd1,
    MODE_DEC   = 2'd2
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_OVERFLOW = 2'd1,
    STAT_FULL     = 2'd2,
    STAT_NO_ENTRY = 2'd3
  } status_t;

  typedef struct packed {
    logic start;
    logic scan;
    logic commit;
  } psrt_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } psrt_sts_t;

endpackage

`default_nettype wire

### rtl/page_share_refcount_table_top.sv
// Top level of the page share refcount table: controller plus datapath.
// Depends on psrt_pkg, psrt_ctrl, psrt_datapath (and through it psrt_ram).
`default_nettype none

// Shared-page reference count table. Each item names an operation (query,
// increment, decrement) on the entry keyed by page frame number and the
// large-page flag; the block answers with one result item holding the count
// after the operation and a status (ok, overflow, table full, decrement with
// no entry). Faults leave the table untouched. Every item scans the whole
// table through the single read port of the entry RAM, one entry per cycle,
// and the next item is taken only once the scan and commit are done. A
// finished result sits in an output register, so the next item is accepted
// while it waits; a result only holds up the block when the following item is
// ready to commit. Empty slots are tracked with per-slot valid bits cleared by
// reset, so the table is usable on the first cycle after reset with no
// clearing pass.

module page_share_refcount_table_top (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [psrt_pkg::MODE_W-1:0]     mode,
  input  wire logic [psrt_pkg::IN_ADDR_W-1:0]  page_address,
  input  wire logic                            is_large_page,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [psrt_pkg::OUT_COUNT_W-1:0]     count,
  output logic [psrt_pkg::STATUS_W-1:0]        status
);

  psrt_pkg::psrt_cmd_t cmd;
  psrt_pkg::psrt_sts_t sts;

  // Sequencing: idle -> scan -> finish
  psrt_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  // Table storage, scan, update and result register
  psrt_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .mode         (mode),
    .page_address (page_address),
    .is_large_page(is_large_page),
    .cmd          (cmd),
    .sts          (sts),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .count        (count),
    .status       (status)
  );

endmodule

`default_nettype wire

### rtl/psrt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module psrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/psrt_ctrl.sv
// Controller state machine: accept, scan, commit.
// Depends on psrt_pkg.
`default_nettype none

module psrt_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire psrt_pkg::psrt_sts_t  sts,
  output psrt_pkg::psrt_cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid;
        if (in_valid) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        // hold until the output register can take the result
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

### rtl/psrt_datapath.sv
// Datapath: request registers, table scan over the entry RAM, update, result.
// Depends on psrt_pkg, psrt_ram and page_share_refcount_table_top_assert.svh.
`default_nettype none

module psrt_datapath (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic [psrt_pkg::MODE_W-1:0]      mode,
  input  wire logic [psrt_pkg::IN_ADDR_W-1:0]   page_address,
  input  wire logic                             is_large_page,
  input  wire psrt_pkg::psrt_cmd_t              cmd,
  output psrt_pkg::psrt_sts_t                   sts,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [psrt_pkg::OUT_COUNT_W-1:0]      count,
  output logic [psrt_pkg::STATUS_W-1:0]         status
);

  localparam int CB = psrt_pkg::COUNT_BITS;
  localparam int AB = psrt_pkg::ADDR_BITS;
  localparam int IW = psrt_pkg::IDX_W;
  localparam int SW = psrt_pkg::SCAN_W;
  localparam int EW = psrt_pkg::ENTRY_W;

  // Request
  logic [psrt_pkg::MODE_W-1:0] req_mode;
  logic [AB-1:0]               req_key;
  logic                        req_large;

  // Scan
  logic [SW-1:0] rd_idx;
  logic          cmp_pending;
  logic [IW-1:0] cmp_idx;
  logic          hit_found;
  logic [IW-1:0] hit_idx;
  logic [CB-1:0] hit_count;
  logic          free_found;
  logic [IW-1:0] free_idx;

  logic [psrt_pkg::TABLE_DEPTH-1:0] valid_bits;

  // RAM
  logic          ram_re;
  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;
  logic [EW-1:0] ram_q;

  logic          q_large;
  logic [AB-1:0] q_key;
  logic [CB-1:0] q_count;
  logic          q_match;
  logic          rd_end;

  // Commit
  logic          set_valid;
  logic          clr_valid;
  logic [CB-1:0] res_count;
  logic [psrt_pkg::STATUS_W-1:0] res_status;

  assign rd_end  = (rd_idx == SW'(psrt_pkg::TABLE_DEPTH));
  assign ram_re  = cmd.scan && !rd_end;

  assign q_large = ram_q[EW-1];
  assign q_key   = ram_q[CB +: AB];
  assign q_count = ram_q[CB-1:0];
  assign q_match = valid_bits[cmp_idx] && (q_key == req_key) && (q_large == req_large);

  assign sts.scan_done = rd_end && !cmp_pending;
  assign sts.out_free  = !out_valid || out_ready;

  psrt_ram #(
    .WIDTH(EW),
    .DEPTH(psrt_pkg::TABLE_DEPTH)
  ) u_entries (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(rd_idx[IW-1:0]),
    .rdata(ram_q)
  );

  // Latch request and walk the table, first match wins
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_mode  <= mode;
      req_key   <= AB'(page_address);
      req_large <= is_large_page;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx      <= '0;
      cmp_pending <= 1'b0;
      hit_found   <= 1'b0;
      free_found  <= 1'b0;
    end else if (cmd.start) begin
      rd_idx      <= '0;
      cmp_pending <= 1'b0;
      hit_found   <= 1'b0;
      free_found  <= 1'b0;
    end else if (cmd.scan) begin
      cmp_pending <= !rd_end;
      if (!rd_end) begin
        rd_idx <= rd_idx + SW'(1);
      end
      if (cmp_pending) begin
        if (q_match && !hit_found) begin
          hit_found <= 1'b1;
        end
        if (!valid_bits[cmp_idx] && !free_found) begin
          free_found <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      cmp_idx <= rd_idx[IW-1:0];
      if (cmp_pending && q_match && !hit_found) begin
        hit_idx   <= cmp_idx;
        hit_count <= q_count;
      end
      if (cmp_pending && !valid_bits[cmp_idx] && !free_found) begin
        free_idx <= cmp_idx;
      end
    end
  end

  // Work out the update and the result
  always_comb begin
    ram_we     = 1'b0;
    ram_waddr  = hit_idx;
    ram_wdata  = {req_large, req_key, hit_count};
    set_valid  = 1'b0;
    clr_valid  = 1'b0;
    res_count  = '0;
    res_status = psrt_pkg::STAT_OK;
    case (req_mode)
      psrt_pkg::MODE_INC: begin
        if (hit_found) begin
          if (hit_count == psrt_pkg::CNT_MAX) begin
            res_status = psrt_pkg::STAT_OVERFLOW;
            res_count  = hit_count;
          end else begin
            res_count = hit_count + CB'(1);
            ram_we    = 1'b1;
            ram_wdata = {req_large, req_key, res_count};
          end
        end else if (free_found) begin
          res_count = CB'(1);
          ram_we    = 1'b1;
          ram_waddr = free_idx;
          ram_wdata = {req_large, req_key, res_count};
          set_valid = 1'b1;
        end else begin
          res_status = psrt_pkg::STAT_FULL;
        end
      end
      psrt_pkg::MODE_DEC: begin
        if (!hit_found) begin
          res_status = psrt_pkg::STAT_NO_ENTRY;
        end else if (hit_count <= CB'(1)) begin
          clr_valid = 1'b1;
        end else begin
          res_count = hit_count - CB'(1);
          ram_we    = 1'b1;
          ram_wdata = {req_large, req_key, res_count};
        end
      end
      default: begin
        if (hit_found) begin
          res_count = hit_count;
        end
      end
    endcase
    ram_we    = ram_we && cmd.commit;
    set_valid = set_valid && cmd.commit;
    clr_valid = clr_valid && cmd.commit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
    end else if (set_valid) begin
      valid_bits[free_idx] <= 1'b1;
    end else if (clr_valid) begin
      valid_bits[hit_idx] <= 1'b0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      count  <= psrt_pkg::OUT_COUNT_W'(res_count);
      status <= res_status;
    end
  end

`include "page_share_refcount_table_top_assert.svh"

  `PSRT_ASSERT_NOW(a_commit_slot_free, cmd.commit, !out_valid || out_ready, "commit over unread result")
  `PSRT_ASSERT_NEXT(a_commit_shows, cmd.commit, out_valid, "result not shown after commit")
  `PSRT_ASSERT_NOW(a_hit_is_valid, cmd.scan && hit_found, valid_bits[hit_idx], "hit on empty slot")
  `PSRT_ASSERT_NOW(a_free_is_empty, cmd.scan && free_found, !valid_bits[free_idx], "free slot in use")

endmodule

`default_nettype wire

### tb/page_share_refcount_table_top_tb.sv
// Self-checking testbench for the page share refcount table.
// Depends on psrt_pkg and page_share_refcount_table_top; scoreboard class and
// stimulus tasks are local to this module.
`timescale 1ns / 1ps

module page_share_refcount_table_top_tb;

  // Mode code the block does not define; it must behave as a query.
  localparam logic [psrt_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
  // Cycles with no handshake on either channel before the run is abandoned.
  // One item scans the whole table and random gaps and stalls add to that;
  // this limit still leaves a wide margin.
  localparam int STALL_LIMIT = 3000;
  // Cycles to keep watching after the last result, about one full scan.
  localparam int DRAIN_CYCLES = 80;
  localparam int POOL_SIZE = 12;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} pacing_t;

  // Shadow copy of the share table plus the queue of expected results.
  class refcount_scoreboard;
    bit                            slot_used  [psrt_pkg::TABLE_DEPTH];
    bit                            slot_large [psrt_pkg::TABLE_DEPTH];
    bit [psrt_pkg::ADDR_BITS-1:0]  slot_addr  [psrt_pkg::TABLE_DEPTH];
    bit [psrt_pkg::COUNT_BITS-1:0] slot_count [psrt_pkg::TABLE_DEPTH];
    logic [psrt_pkg::OUT_COUNT_W-1:0] want_count_q[$];
    psrt_pkg::status_t                want_status_q[$];
    int errors, items, checked;
    int n_overflow, n_full, n_no_entry, n_freed;

    function int pending();
      return want_count_q.size();
    endfunction

    function void flag_error(string msg);
      errors++;
      if (errors <= 10) $display("MISMATCH at %0t: %s", $realtime, msg);
    endfunction

    // Apply one accepted item to the shadow table and queue its result.
    function void note_item(logic [psrt_pkg::MODE_W-1:0] op,
                            logic [psrt_pkg::IN_ADDR_W-1:0] page,
                            logic lpage);
      logic [psrt_pkg::ADDR_BITS-1:0]  key_addr;
      logic [psrt_pkg::COUNT_BITS-1:0] after;
      psrt_pkg::status_t               st;
      int                              hit;
      int                              free_slot;
      key_addr  = page[psrt_pkg::ADDR_BITS-1:0];
      after     = '0;
      st        = psrt_pkg::STAT_OK;
      hit       = -1;
      free_slot = -1;
      items++;
      // Walk downward so the lowest matching and lowest free slot win.
      for (int i = psrt_pkg::TABLE_DEPTH - 1; i >= 0; i--) begin
        if (slot_used[i] && slot_addr[i] == key_addr && slot_large[i] == lpage)
          hit = i;
        if (!slot_used[i]) free_slot = i;
      end
      case (op)
        psrt_pkg::MODE_INC: begin
          if (hit >= 0) begin
            if (slot_count[hit] >= psrt_pkg::CNT_MAX) begin
              st = psrt_pkg::STAT_OVERFLOW;
              n_overflow++;
            end else begin
              slot_count[hit]++;
            end
            after = slot_count[hit];
          end else if (free_slot < 0) begin
            st = psrt_pkg::STAT_FULL;
            n_full++;
          end else begin
            slot_used[free_slot]  = 1'b1;
            slot_large[free_slot] = lpage;
            slot_addr[free_slot]  = key_addr;
            slot_count[free_slot] = psrt_pkg::COUNT_BITS'(1);
            after = psrt_pkg::COUNT_BITS'(1);
          end
        end
        psrt_pkg::MODE_DEC: begin
          if (hit < 0) begin
            st = psrt_pkg::STAT_NO_ENTRY;
            n_no_entry++;
          end else if (slot_count[hit] <= 1) begin
            slot_used[hit]  = 1'b0;
            slot_large[hit] = 1'b0;
            slot_addr[hit]  = '0;
            slot_count[hit] = '0;
            n_freed++;
          end else begin
            slot_count[hit]--;
            after = slot_count[hit];
          end
        end
        default: begin
          if (hit >= 0) after = slot_count[hit];
        end
      endcase
      want_count_q.push_back(psrt_pkg::OUT_COUNT_W'(after));
      want_status_q.push_back(st);
    endfunction

    // Compare one accepted result with the oldest expectation.
    function void check_result(logic [psrt_pkg::OUT_COUNT_W-1:0] got_count,
                               logic [psrt_pkg::STATUS_W-1:0] got_status);
      logic [psrt_pkg::OUT_COUNT_W-1:0] want_count;
      psrt_pkg::status_t                want_status;
      if (want_count_q.size() == 0) begin
        flag_error($sformatf("result with nothing pending: count %0d status %0d",
                             got_count, got_status));
        return;
      end
      want_count  = want_count_q.pop_front();
      want_status = want_status_q.pop_front();
      checked++;
      if (got_count !== want_count)
        flag_error($sformatf("result %0d count: expected %0d, got %0d",
                             checked, want_count, got_count));
      if (got_status !== want_status)
        flag_error($sformatf("result %0d status: expected %0d, got %0d",
                             checked, want_status, got_status));
    endfunction
  endclass

  logic                             clk;
  logic                             rst;
  logic                             in_valid;
  logic                             in_ready;
  logic [psrt_pkg::MODE_W-1:0]      mode;
  logic [psrt_pkg::IN_ADDR_W-1:0]   page_address;
  logic                             is_large_page;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  logic [psrt_pkg::OUT_COUNT_W-1:0] count;
  logic [psrt_pkg::STATUS_W-1:0]    status;

  refcount_scoreboard sb;
  pacing_t            pacing = IDLE_NONE;
  int                 quiet_cycles = 0;

  page_share_refcount_table_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .mode          (mode),
    .page_address  (page_address),
    .is_large_page (is_large_page),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .count         (count),
    .status        (status)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Receiver: drop ready at random in the stalling phases, hold it high
  // otherwise. Changes land on the falling edge like every other input.
  always @(negedge clk) begin
    case (pacing)
      IDLE_RECV: out_ready <= ($urandom_range(99) >= 55);
      IDLE_BOTH: out_ready <= ($urandom_range(99) >= 36);
      default:   out_ready <= 1'b1;
    endcase
  end

  // Result monitor: sample at the rising edge, before the block updates.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(count, status);
  end

  // Watchdog: count cycles with no handshake on either channel.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Timeout: no handshake for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, sb.pending());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Decide whether the sender sits out this cycle.
  function automatic bit sender_waits();
    case (pacing)
      IDLE_SEND: return $urandom_range(99) < 55;
      IDLE_BOTH: return $urandom_range(99) < 36;
      default:   return 1'b0;
    endcase
  endfunction

  // Present one item and hold it until accepted. Entered and left at a
  // falling edge; valid is left high so back-to-back items never drop it.
  task automatic send_item(input logic [psrt_pkg::MODE_W-1:0] op,
                           input logic [psrt_pkg::IN_ADDR_W-1:0] page,
                           input logic lpage);
    while (sender_waits()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    mode          <= op;
    page_address  <= page;
    is_large_page <= lpage;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_item(op, page, lpage);
    @(negedge clk);
  endtask

  // Park the sender until every expected result has come back.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // Directed opening: empty-table lookups, size flag as part of the key,
  // address extremes, freeing the last reference, reuse of a freed slot,
  // and the unused mode code.
  task automatic run_directed();
    send_item(psrt_pkg::MODE_QUERY, '0, 1'b0);         // nothing there yet
    send_item(psrt_pkg::MODE_DEC,   '0, 1'b0);         // decrement with no entry
    send_item(psrt_pkg::MODE_INC,   '0, 1'b0);
    send_item(psrt_pkg::MODE_INC,   '0, 1'b0);
    send_item(psrt_pkg::MODE_QUERY, '0, 1'b1);         // same frame, other size
    send_item(psrt_pkg::MODE_INC,   '0, 1'b1);
    send_item(psrt_pkg::MODE_INC,   '1, 1'b1);
    send_item(psrt_pkg::MODE_INC,   '1, 1'b0);
    send_item(MODE_UNUSED,          '1, 1'b1);         // reads like a query
    send_item(psrt_pkg::MODE_QUERY, '0, 1'b0);
    send_item(psrt_pkg::MODE_DEC,   '0, 1'b0);
    send_item(psrt_pkg::MODE_DEC,   '0, 1'b0);         // last reference: freed
    send_item(psrt_pkg::MODE_DEC,   '0, 1'b0);         // gone now
    send_item(psrt_pkg::MODE_QUERY, '0, 1'b0);
    send_item(psrt_pkg::MODE_INC,   20'h55555, 1'b0);  // takes the freed slot
    send_item(psrt_pkg::MODE_INC,   20'hAAAAA, 1'b1);
    send_item(psrt_pkg::MODE_DEC,   '1, 1'b1);
    send_item(psrt_pkg::MODE_DEC,   '1, 1'b0);
    send_item(psrt_pkg::MODE_DEC,   '0, 1'b1);
    send_item(MODE_UNUSED,          20'hAAAAA, 1'b0);
    send_item(psrt_pkg::MODE_DEC,   20'h55555, 1'b0);
    send_item(psrt_pkg::MODE_DEC,   20'hAAAAA, 1'b1);
  endtask

  // Random traffic on a small pool of hot pages so counts build up and
  // entries come and go; a few items use fully random fields.
  task automatic random_ops(input int n_items);
    logic [psrt_pkg::IN_ADDR_W-1:0] pool_page[POOL_SIZE];
    logic                           pool_large[POOL_SIZE];
    int                             pick;
    int                             roll;
    for (int k = 0; k < POOL_SIZE; k++) begin
      pool_page[k]  = psrt_pkg::IN_ADDR_W'($urandom());
      pool_large[k] = 1'($urandom());
    end
    // Keep one frame under both page sizes.
    pool_page[1]  = pool_page[0];
    pool_large[1] = !pool_large[0];
    repeat (n_items) begin
      pick = $urandom_range(POOL_SIZE - 1);
      roll = $urandom_range(99);
      if (roll < 40)
        send_item(psrt_pkg::MODE_INC, pool_page[pick], pool_large[pick]);
      else if (roll < 70)
        send_item(psrt_pkg::MODE_DEC, pool_page[pick], pool_large[pick]);
      else if (roll < 88)
        send_item(psrt_pkg::MODE_QUERY, pool_page[pick], pool_large[pick]);
      else if (roll < 93)
        send_item(MODE_UNUSED, pool_page[pick], pool_large[pick]);
      else
        send_item(psrt_pkg::MODE_W'($urandom()), psrt_pkg::IN_ADDR_W'($urandom()),
                  1'($urandom()));
    end
  endtask

  // Fill every slot, hit the full table from several angles, open a hole
  // and refill it, then drain its own entries again.
  task automatic fill_and_drain();
    logic [psrt_pkg::IN_ADDR_W-1:0] base;
    base = psrt_pkg::IN_ADDR_W'($urandom());
    for (int i = 0; i < psrt_pkg::TABLE_DEPTH; i++)
      send_item(psrt_pkg::MODE_INC, base + psrt_pkg::IN_ADDR_W'(i), 1'b0);
    send_item(psrt_pkg::MODE_INC,   base, 1'b1);     // no room for the large twin
    send_item(psrt_pkg::MODE_INC,   base, 1'b0);     // existing entry counts up
    send_item(psrt_pkg::MODE_QUERY, base, 1'b1);
    send_item(psrt_pkg::MODE_DEC,   base, 1'b1);
    send_item(psrt_pkg::MODE_DEC,   base + psrt_pkg::IN_ADDR_W'(10), 1'b0);
    send_item(psrt_pkg::MODE_INC,   base, 1'b1);     // lands in the hole
    send_item(psrt_pkg::MODE_INC,
              base + psrt_pkg::IN_ADDR_W'(psrt_pkg::TABLE_DEPTH), 1'b1);
    send_item(psrt_pkg::MODE_DEC,   base, 1'b1);
    send_item(psrt_pkg::MODE_DEC,   base, 1'b0);
    for (int i = 0; i < psrt_pkg::TABLE_DEPTH; i++)
      send_item(psrt_pkg::MODE_DEC, base + psrt_pkg::IN_ADDR_W'(i), 1'b0);
  endtask

  // Drive one page to the top of the count range and past it, rotating
  // through every pacing mode on the way.
  task automatic pump_to_overflow();
    logic [psrt_pkg::IN_ADDR_W-1:0] page;
    logic                           lpage;
    page  = psrt_pkg::IN_ADDR_W'($urandom());
    lpage = 1'($urandom());
    for (int i = 0; i < int'(psrt_pkg::CNT_MAX) + 3; i++) begin
      pacing = pacing_t'((i / 128) % 4);
      send_item(psrt_pkg::MODE_INC, page, lpage);
    end
    send_item(psrt_pkg::MODE_QUERY, page, lpage);
    send_item(MODE_UNUSED,          page, lpage);
    send_item(psrt_pkg::MODE_DEC,   page, lpage);
    send_item(psrt_pkg::MODE_INC,   page, lpage);
    send_item(psrt_pkg::MODE_INC,   page, lpage);   // over the top again
    send_item(psrt_pkg::MODE_DEC,   page, lpage);
  endtask

  initial begin
    sb            = new();
    rst           = 1'b1;
    in_valid      = 1'b0;
    mode          = psrt_pkg::MODE_QUERY;
    page_address  = '0;
    is_large_page = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    pacing = IDLE_NONE;
    run_directed();
    wait_for_results();              // sender holds off until all results return
    pacing = IDLE_SEND;
    random_ops(300);
    pacing = IDLE_RECV;
    fill_and_drain();
    wait_for_results();
    pump_to_overflow();
    pacing = IDLE_BOTH;
    random_ops(200);
    pacing = IDLE_NONE;
    random_ops(100);
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d items and %0d results across all pacing modes.",
             sb.items, sb.checked);
    $display("Faults seen: %0d overflow, %0d table full, %0d missing entry; %0d freed.",
             sb.n_overflow, sb.n_full, sb.n_no_entry, sb.n_freed);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches, %0d results outstanding", sb.errors, sb.pending());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
